>>> hw/rtl/line_frustum_clipper_core_macros.svh
// ----------------------------------------------------------------------------
// line_frustum_clipper_core_macros
// Assertion helpers for the checker file of the clipper.
// ----------------------------------------------------------------------------
`ifndef LINE_FRUSTUM_CLIPPER_CORE_MACROS_SVH
`define LINE_FRUSTUM_CLIPPER_CORE_MACROS_SVH

// same-cycle implication, off during reset
`define LFC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define LFC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// state in the cycle after reset
`define LFC_ASSERT_RST(lbl, cons, msg) \
  lbl: assert property (@(posedge clk) rst |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/lfc_pkg.sv
// ----------------------------------------------------------------------------
// lfc_pkg
// Types, constants and fixed-point helpers of the line frustum clipper.
// ----------------------------------------------------------------------------
package lfc_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int COORD_WIDTH = 32;
  localparam int NUM_PLANES  = 5;
  localparam int CFG_IDX_W   = 2;

  localparam logic [CFG_IDX_W-1:0] REG_NEAR_Z  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SLOPE_X = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_SLOPE_Y = CFG_IDX_W'(2);

  // divider: quotient bits resolved per stage
  localparam int DIV_STEP   = 4;
  localparam int NUM_W      = COORD_WIDTH + FRAC_BITS;
  localparam int DIV_STAGES = (NUM_W + DIV_STEP - 1) / DIV_STEP;
  localparam int PAD_W      = DIV_STAGES * DIV_STEP;

  typedef logic signed [COORD_WIDTH-1:0]   coord_t;
  typedef logic signed [2*COORD_WIDTH-1:0] prod_t;

  localparam coord_t FP_ONE = coord_t'(longint'(1) << FRAC_BITS);

  typedef enum logic [2:0] {
    PL_NEAR   = 3'd0,
    PL_LEFT   = 3'd1,
    PL_RIGHT  = 3'd2,
    PL_TOP    = 3'd3,
    PL_BOTTOM = 3'd4
  } plane_t;

  typedef struct packed {
    coord_t a_x;
    coord_t a_y;
    coord_t a_z;
    coord_t b_x;
    coord_t b_y;
    coord_t b_z;
  } seg_t;

  typedef struct packed {
    seg_t                  seg;
    logic                  rej;
    logic [NUM_PLANES-1:0] diff;
  } tok_t;

  typedef struct packed {
    coord_t near_z;
    coord_t slope_x;
    coord_t slope_y;
  } cfg_t;

  // travels beside the divider; sel_a: endpoint a is the outside one
  typedef struct packed {
    tok_t   tok;
    logic   act;
    logic   sel_a;
    coord_t d_x;
    coord_t d_y;
    coord_t d_z;
  } side_t;

  localparam cfg_t CFG_RESET = '{near_z: FP_ONE, slope_x: FP_ONE, slope_y: FP_ONE};

  function automatic prod_t smul(coord_t a, coord_t b);
    return prod_t'(a) * prod_t'(b);
  endfunction

  // floor shift and wrap to coordinate width
  function automatic coord_t fx_round(prod_t p);
    prod_t s;
    s = p >>> FRAC_BITS;
    return s[COORD_WIDTH-1:0];
  endfunction

endpackage

>>> hw/rtl/lfc_if.sv
// ----------------------------------------------------------------------------
// lfc_if
// Valid/ready channels of the clipper: segment in, result out, config write.
// ----------------------------------------------------------------------------
interface lfc_seg_if;
  logic           valid;
  logic           ready;
  lfc_pkg::coord_t a_x;
  lfc_pkg::coord_t a_y;
  lfc_pkg::coord_t a_z;
  lfc_pkg::coord_t b_x;
  lfc_pkg::coord_t b_y;
  lfc_pkg::coord_t b_z;

  modport source (output valid, a_x, a_y, a_z, b_x, b_y, b_z, input ready);
  modport sink   (input valid, a_x, a_y, a_z, b_x, b_y, b_z, output ready);
endinterface

interface lfc_res_if;
  logic           valid;
  logic           ready;
  logic           rejected;
  lfc_pkg::coord_t out_a_x;
  lfc_pkg::coord_t out_a_y;
  lfc_pkg::coord_t out_a_z;
  lfc_pkg::coord_t out_b_x;
  lfc_pkg::coord_t out_b_y;
  lfc_pkg::coord_t out_b_z;

  modport source (output valid, rejected, out_a_x, out_a_y, out_a_z,
                  out_b_x, out_b_y, out_b_z, input ready);
  modport sink   (input valid, rejected, out_a_x, out_a_y, out_a_z,
                  out_b_x, out_b_y, out_b_z, output ready);
endinterface

interface lfc_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [lfc_pkg::CFG_IDX_W-1:0]  index;
  lfc_pkg::coord_t                wdata;

  modport source (output valid, index, wdata, input ready);
  modport sink   (input valid, index, wdata, output ready);
endinterface

>>> hw/rtl/lfc_outcode.sv
// ----------------------------------------------------------------------------
// lfc_outcode
// Two-stage outcode unit: side limits z*slope, then plane compares and the
// trivial reject / differing-plane mask.
// ----------------------------------------------------------------------------
module lfc_outcode (
  input  logic          clk,
  input  logic          rst,
  input  logic          adv,
  input  lfc_pkg::cfg_t cfg,
  input  logic          in_valid,
  input  lfc_pkg::seg_t in_seg,
  output logic          out_valid,
  output lfc_pkg::tok_t out_tok
);

  logic           v0;
  lfc_pkg::seg_t  s0;
  lfc_pkg::prod_t pwa, pha, pwb, phb;

  logic [lfc_pkg::NUM_PLANES-1:0] ca, cb;
  lfc_pkg::coord_t wa, ha, wb, hb;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0        <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v0        <= in_valid;
      out_valid <= v0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0  <= in_seg;
      pwa <= lfc_pkg::smul(in_seg.a_z, cfg.slope_x);
      pha <= lfc_pkg::smul(in_seg.a_z, cfg.slope_y);
      pwb <= lfc_pkg::smul(in_seg.b_z, cfg.slope_x);
      phb <= lfc_pkg::smul(in_seg.b_z, cfg.slope_y);
    end
  end

  always_comb begin
    wa = lfc_pkg::fx_round(pwa);
    ha = lfc_pkg::fx_round(pha);
    wb = lfc_pkg::fx_round(pwb);
    hb = lfc_pkg::fx_round(phb);
    ca[lfc_pkg::PL_NEAR]   = s0.a_z < cfg.near_z;
    ca[lfc_pkg::PL_LEFT]   = s0.a_x < -wa;
    ca[lfc_pkg::PL_RIGHT]  = s0.a_x > wa;
    ca[lfc_pkg::PL_TOP]    = s0.a_y < -ha;
    ca[lfc_pkg::PL_BOTTOM] = s0.a_y > ha;
    cb[lfc_pkg::PL_NEAR]   = s0.b_z < cfg.near_z;
    cb[lfc_pkg::PL_LEFT]   = s0.b_x < -wb;
    cb[lfc_pkg::PL_RIGHT]  = s0.b_x > wb;
    cb[lfc_pkg::PL_TOP]    = s0.b_y < -hb;
    cb[lfc_pkg::PL_BOTTOM] = s0.b_y > hb;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_tok.seg  <= s0;
      out_tok.rej  <= |(ca & cb);
      out_tok.diff <= (|(ca & cb)) ? '0 : (ca ^ cb);
    end
  end

endmodule

>>> hw/rtl/lfc_div.sv
// ----------------------------------------------------------------------------
// lfc_div
// Pipelined restoring divider, unsigned, DIV_STEP quotient bits per stage.
// Carries the clip side data alongside.
// ----------------------------------------------------------------------------
module lfc_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          adv,
  input  logic                          in_valid,
  input  lfc_pkg::side_t                in_side,
  input  logic [lfc_pkg::PAD_W-1:0]     in_num,
  input  logic [lfc_pkg::COORD_WIDTH-1:0] in_den,
  output logic                          out_valid,
  output lfc_pkg::side_t                out_side,
  output logic [lfc_pkg::COORD_WIDTH-1:0] out_quo,
  output logic                          out_den_zero
);

  localparam int CW = lfc_pkg::COORD_WIDTH;
  localparam int NS = lfc_pkg::DIV_STAGES;
  localparam int PW = lfc_pkg::PAD_W;

  logic [NS-1:0]  vld;
  logic [CW:0]    rem_r  [NS];
  logic [PW-1:0]  num_r  [NS];
  logic [PW-1:0]  quo_r  [NS];
  logic [CW-1:0]  den_r  [NS];
  lfc_pkg::side_t side_r [NS];

  for (genvar k = 0; k < NS; k++) begin : g_st
    logic           v_i;
    logic [CW:0]    r_i, r_c;
    logic [PW-1:0]  n_i, n_c, q_i, q_c;
    logic [CW-1:0]  d_i;
    lfc_pkg::side_t s_i;

    if (k == 0) begin : g_first
      assign v_i = in_valid;
      assign r_i = '0;
      assign n_i = in_num;
      assign q_i = '0;
      assign d_i = in_den;
      assign s_i = in_side;
    end else begin : g_next
      assign v_i = vld[k-1];
      assign r_i = rem_r[k-1];
      assign n_i = num_r[k-1];
      assign q_i = quo_r[k-1];
      assign d_i = den_r[k-1];
      assign s_i = side_r[k-1];
    end

    always_comb begin
      r_c = r_i;
      n_c = n_i;
      q_c = q_i;
      for (int j = 0; j < lfc_pkg::DIV_STEP; j++) begin
        r_c = {r_c[CW-1:0], n_c[PW-1]};
        n_c = n_c << 1;
        q_c = q_c << 1;
        if (r_c >= {1'b0, d_i}) begin
          r_c    = r_c - {1'b0, d_i};
          q_c[0] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (adv) begin
        vld[k] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[k]  <= r_c;
        num_r[k]  <= n_c;
        quo_r[k]  <= q_c;
        den_r[k]  <= d_i;
        side_r[k] <= s_i;
      end
    end
  end

  assign out_valid    = vld[NS-1];
  assign out_side     = side_r[NS-1];
  assign out_quo      = quo_r[NS-1][CW-1:0];
  assign out_den_zero = (den_r[NS-1] == '0);

endmodule

>>> hw/rtl/lfc_clip.sv
// ----------------------------------------------------------------------------
// lfc_clip
// One plane of the clipper: distances, side select, pipelined divide,
// interpolation multiply and endpoint update.
// ----------------------------------------------------------------------------
module lfc_clip (
  input  logic            clk,
  input  logic            rst,
  input  logic            adv,
  input  lfc_pkg::plane_t plane,
  input  lfc_pkg::cfg_t   cfg,
  input  logic            in_valid,
  input  lfc_pkg::tok_t   in_tok,
  output logic            out_valid,
  output lfc_pkg::tok_t   out_tok
);

  localparam int CW = lfc_pkg::COORD_WIDTH;
  localparam int FB = lfc_pkg::FRAC_BITS;
  localparam int PW = lfc_pkg::PAD_W;

  // stage 0: z*slope
  logic            v0;
  lfc_pkg::tok_t   t0;
  lfc_pkg::prod_t  pa, pb;
  lfc_pkg::coord_t slope;

  assign slope = (plane == lfc_pkg::PL_TOP || plane == lfc_pkg::PL_BOTTOM) ?
                 cfg.slope_y : cfg.slope_x;

  always_ff @(posedge clk) begin
    if (adv) begin
      t0 <= in_tok;
      pa <= lfc_pkg::smul(in_tok.seg.a_z, slope);
      pb <= lfc_pkg::smul(in_tok.seg.b_z, slope);
    end
  end

  // stage 1: signed distances, positive inside
  logic            v1;
  lfc_pkg::tok_t   t1;
  lfc_pkg::coord_t da, db, da_c, db_c, ma, mb;

  always_comb begin
    ma = lfc_pkg::fx_round(pa);
    mb = lfc_pkg::fx_round(pb);
    unique case (plane)
      lfc_pkg::PL_NEAR: begin
        da_c = t0.seg.a_z - cfg.near_z;
        db_c = t0.seg.b_z - cfg.near_z;
      end
      lfc_pkg::PL_LEFT: begin
        da_c = t0.seg.a_x + ma;
        db_c = t0.seg.b_x + mb;
      end
      lfc_pkg::PL_RIGHT: begin
        da_c = ma - t0.seg.a_x;
        db_c = mb - t0.seg.b_x;
      end
      lfc_pkg::PL_TOP: begin
        da_c = t0.seg.a_y + ma;
        db_c = t0.seg.b_y + mb;
      end
      default: begin
        da_c = mb - mb + ma - t0.seg.a_y;
        db_c = mb - t0.seg.b_y;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t1 <= t0;
      da <= da_c;
      db <= db_c;
    end
  end

  // stage 2: choose the outside endpoint, divisor and deltas
  logic                v2;
  lfc_pkg::side_t      s2, s2_c;
  logic [PW-1:0]       num2;
  logic [CW-1:0]       len2;
  lfc_pkg::coord_t     din, dout;

  always_comb begin
    s2_c.tok   = t1;
    s2_c.sel_a = da[CW-1];
    s2_c.act   = t1.diff[plane] && (da[CW-1] != db[CW-1]);
    din        = da[CW-1] ? db : da;
    dout       = da[CW-1] ? da : db;
    if (da[CW-1]) begin
      s2_c.d_x = t1.seg.a_x - t1.seg.b_x;
      s2_c.d_y = t1.seg.a_y - t1.seg.b_y;
      s2_c.d_z = t1.seg.a_z - t1.seg.b_z;
    end else begin
      s2_c.d_x = t1.seg.b_x - t1.seg.a_x;
      s2_c.d_y = t1.seg.b_y - t1.seg.a_y;
      s2_c.d_z = t1.seg.b_z - t1.seg.a_z;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2   <= s2_c;
      num2 <= PW'({din, {FB{1'b0}}});
      len2 <= CW'(din - dout);
    end
  end

  // divide
  logic           v3;
  lfc_pkg::side_t s3;
  logic [CW-1:0]  quo3;
  logic           dz3;

  lfc_div u_div (
    .clk          (clk),
    .rst          (rst),
    .adv          (adv),
    .in_valid     (v2),
    .in_side      (s2),
    .in_num       (num2),
    .in_den       (len2),
    .out_valid    (v3),
    .out_side     (s3),
    .out_quo      (quo3),
    .out_den_zero (dz3)
  );

  // stage 4: delta * s
  logic            v4;
  lfc_pkg::side_t  s4;
  lfc_pkg::prod_t  px, py, pz;
  lfc_pkg::coord_t sfac;

  assign sfac = dz3 ? lfc_pkg::FP_ONE : lfc_pkg::coord_t'(quo3);

  always_ff @(posedge clk) begin
    if (adv) begin
      s4 <= s3;
      px <= lfc_pkg::smul(s3.d_x, sfac);
      py <= lfc_pkg::smul(s3.d_y, sfac);
      pz <= lfc_pkg::smul(s3.d_z, sfac);
    end
  end

  // stage 5: move the outside endpoint
  lfc_pkg::tok_t   t5_c;
  lfc_pkg::coord_t rx, ry, rz;

  always_comb begin
    t5_c = s4.tok;
    if (s4.sel_a) begin
      rx = s4.tok.seg.b_x + lfc_pkg::fx_round(px);
      ry = s4.tok.seg.b_y + lfc_pkg::fx_round(py);
      rz = s4.tok.seg.b_z + lfc_pkg::fx_round(pz);
    end else begin
      rx = s4.tok.seg.a_x + lfc_pkg::fx_round(px);
      ry = s4.tok.seg.a_y + lfc_pkg::fx_round(py);
      rz = s4.tok.seg.a_z + lfc_pkg::fx_round(pz);
    end
    if (s4.act && s4.sel_a) begin
      t5_c.seg.a_x = rx;
      t5_c.seg.a_y = ry;
      t5_c.seg.a_z = rz;
    end else if (s4.act) begin
      t5_c.seg.b_x = rx;
      t5_c.seg.b_y = ry;
      t5_c.seg.b_z = rz;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_tok <= t5_c;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0        <= 1'b0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v0        <= in_valid;
      v1        <= v0;
      v2        <= v1;
      v4        <= v3;
      out_valid <= v4;
    end
  end

endmodule

>>> hw/rtl/line_frustum_clipper_core.sv
// ----------------------------------------------------------------------------
// line_frustum_clipper_core
// 3D segment clipper against near, left, right, top and bottom planes.
//
//   channel | dir | words                               | accepted when
//   seg     | in  | a_x a_y a_z b_x b_y b_z             | valid & ready
//   res     | out | rejected out_a_* out_b_*            | valid & ready
//   cfg     | in  | index wdata (near_z slope_x slope_y)| valid & ready
//
// One word per cycle in and out while the output buffer is not full. Stages:
// 2 outcode, 5 planes x 17 (the 12-stage divider sets most of it), 1 output reg.
// Reset clears valid bits and loads 1.0 into all three registers; cfg is
// always ready. A 2-entry output buffer stalls the whole pipeline only
// when both entries hold words.
// ----------------------------------------------------------------------------
module line_frustum_clipper_core (
  input  logic       clk,
  input  logic       rst,
  lfc_seg_if.sink    seg,
  lfc_res_if.source  res,
  lfc_cfg_if.sink    cfg
);

  localparam int NP = lfc_pkg::NUM_PLANES;

  lfc_pkg::cfg_t cfg_r;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_r <= lfc_pkg::CFG_RESET;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        lfc_pkg::REG_NEAR_Z:  cfg_r.near_z  <= cfg.wdata;
        lfc_pkg::REG_SLOPE_X: cfg_r.slope_x <= cfg.wdata;
        lfc_pkg::REG_SLOPE_Y: cfg_r.slope_y <= cfg.wdata;
        default: ;
      endcase
    end
  end

  logic adv;
  logic ov, sv;
  lfc_pkg::tok_t od, sd;

  assign adv       = !sv;
  assign seg.ready = adv;

  lfc_pkg::seg_t in_seg;
  assign in_seg = '{a_x: seg.a_x, a_y: seg.a_y, a_z: seg.a_z,
                    b_x: seg.b_x, b_y: seg.b_y, b_z: seg.b_z};

  logic [NP:0]   cvld;
  lfc_pkg::tok_t ctok [NP+1];

  lfc_outcode u_outcode (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .cfg       (cfg_r),
    .in_valid  (seg.valid),
    .in_seg    (in_seg),
    .out_valid (cvld[0]),
    .out_tok   (ctok[0])
  );

  for (genvar p = 0; p < NP; p++) begin : g_plane
    lfc_clip u_clip (
      .clk       (clk),
      .rst       (rst),
      .adv       (adv),
      .plane     (lfc_pkg::plane_t'(p)),
      .cfg       (cfg_r),
      .in_valid  (cvld[p]),
      .in_tok    (ctok[p]),
      .out_valid (cvld[p+1]),
      .out_tok   (ctok[p+1])
    );
  end

  logic push, pop;
  assign push = adv && cvld[NP];
  assign pop  = ov && res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
      sv <= 1'b0;
    end else begin
      priority if (sv) begin
        if (pop) begin
          sv <= 1'b0;
        end
      end else if (push && ov && !pop) begin
        sv <= 1'b1;
      end else if (push) begin
        ov <= 1'b1;
      end else if (pop) begin
        ov <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sv && pop) begin
      od <= sd;
    end else if (push && ov && !pop) begin
      sd <= ctok[NP];
    end else if (push) begin
      od <= ctok[NP];
    end
  end

  assign res.valid    = ov;
  assign res.rejected = od.rej;
  assign res.out_a_x  = od.seg.a_x;
  assign res.out_a_y  = od.seg.a_y;
  assign res.out_a_z  = od.seg.a_z;
  assign res.out_b_x  = od.seg.b_x;
  assign res.out_b_y  = od.seg.b_y;
  assign res.out_b_z  = od.seg.b_z;

endmodule

>>> hw/rtl/lfc_checker.sv
// ----------------------------------------------------------------------------
// lfc_checker
// Port-level checks of the clipper, bound to the top level.
// ----------------------------------------------------------------------------
`include "line_frustum_clipper_core_macros.svh"

module lfc_checker (
  input logic            clk,
  input logic            rst,
  input logic            seg_ready,
  input logic            res_valid,
  input logic            res_ready,
  input logic            res_rejected,
  input lfc_pkg::coord_t res_a_x,
  input lfc_pkg::coord_t res_a_y,
  input lfc_pkg::coord_t res_a_z,
  input lfc_pkg::coord_t res_b_x,
  input lfc_pkg::coord_t res_b_y,
  input lfc_pkg::coord_t res_b_z
);

  logic [6*lfc_pkg::COORD_WIDTH:0] res_word;
  logic                            res_stall;

  assign res_word  = {res_rejected, res_a_x, res_a_y, res_a_z,
                      res_b_x, res_b_y, res_b_z};
  assign res_stall = res_valid && !res_ready;

  `LFC_ASSERT_NEXT(a_res_hold, res_stall, res_valid, "res word dropped while stalled")
  `LFC_ASSERT_NEXT(a_res_stable, res_stall, $stable(res_word), "res word changed while stalled")
  `LFC_ASSERT_NOW(a_empty_ready, !res_valid, seg_ready, "input stalled with empty output")
  `LFC_ASSERT_RST(a_reset_state, !res_valid && seg_ready, "bad state after reset")

endmodule

bind line_frustum_clipper_core lfc_checker u_lfc_checker (
  .clk          (clk),
  .rst          (rst),
  .seg_ready    (seg.ready),
  .res_valid    (res.valid),
  .res_ready    (res.ready),
  .res_rejected (res.rejected),
  .res_a_x      (res.out_a_x),
  .res_a_y      (res.out_a_y),
  .res_a_z      (res.out_a_z),
  .res_b_x      (res.out_b_x),
  .res_b_y      (res.out_b_y),
  .res_b_z      (res.out_b_z)
);

>>> tb/sv/line_frustum_clipper_core_test.sv
// ----------------------------------------------------------------------------
// line_frustum_clipper_core_test
// Drives segments through the clipper with random bursts and output stalls,
// predicts each clipped segment, and compares every output word in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module line_frustum_clipper_core_test;

  localparam int LATENCY = 88;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic            rejected;
    lfc_pkg::coord_t a_x, a_y, a_z, b_x, b_y, b_z;
  } clip_res_t;

  logic clk = 0;
  logic rst = 1;
  always #1 clk = ~clk;

  lfc_seg_if seg();
  lfc_res_if res();
  lfc_cfg_if cfg();

  line_frustum_clipper_core DUT (.clk(clk), .rst(rst), .seg(seg), .res(res), .cfg(cfg));

  lfc_pkg::cfg_t frustum;
  lfc_pkg::seg_t pending_segs[$];
  clip_res_t     expected_clips[$];
  int            errors = 0;
  longint        cycles = 0;
  int            burst_left = 0, gap_left = 0;
  int            hold_off = 0;
  logic          inputs_done = 0;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  function automatic lfc_pkg::coord_t fx_mul(lfc_pkg::coord_t a, lfc_pkg::coord_t b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b);
    p = p >>> lfc_pkg::FRAC_BITS;
    return p[31:0];
  endfunction

  function automatic logic [4:0] outcode(lfc_pkg::coord_t x, lfc_pkg::coord_t y,
                                         lfc_pkg::coord_t z);
    lfc_pkg::coord_t w, h;
    logic [4:0] c;
    w = fx_mul(z, frustum.slope_x);
    h = fx_mul(z, frustum.slope_y);
    c[lfc_pkg::PL_NEAR]   = z < frustum.near_z;
    c[lfc_pkg::PL_LEFT]   = x < -w;
    c[lfc_pkg::PL_RIGHT]  = x > w;
    c[lfc_pkg::PL_TOP]    = y < -h;
    c[lfc_pkg::PL_BOTTOM] = y > h;
    return c;
  endfunction

  function automatic lfc_pkg::coord_t plane_dist(lfc_pkg::coord_t p[3],
                                                 lfc_pkg::plane_t pl);
    case (pl)
      lfc_pkg::PL_NEAR:  return p[2] - frustum.near_z;
      lfc_pkg::PL_LEFT:  return p[0] + fx_mul(p[2], frustum.slope_x);
      lfc_pkg::PL_RIGHT: return fx_mul(p[2], frustum.slope_x) - p[0];
      lfc_pkg::PL_TOP:   return p[1] + fx_mul(p[2], frustum.slope_y);
      default:           return fx_mul(p[2], frustum.slope_y) - p[1];
    endcase
  endfunction

  function automatic clip_res_t clip_segment(lfc_pkg::seg_t s);
    lfc_pkg::coord_t a[3], b[3], pin[3], pout[3];
    lfc_pkg::coord_t da, db, din, dout, len, sc;
    logic [47:0] num;
    logic [4:0] ca, cb, diff;
    logic a_out;
    clip_res_t r;
    a = '{s.a_x, s.a_y, s.a_z};
    b = '{s.b_x, s.b_y, s.b_z};
    ca = outcode(a[0], a[1], a[2]);
    cb = outcode(b[0], b[1], b[2]);
    r.rejected = |(ca & cb);
    if (!r.rejected) begin
      diff = ca ^ cb;
      for (int pl = 0; pl < 5; pl++) begin
        if (!diff[pl]) continue;
        da = plane_dist(a, lfc_pkg::plane_t'(pl));
        db = plane_dist(b, lfc_pkg::plane_t'(pl));
        if (da[31] == db[31]) continue;
        a_out = da[31];
        if (a_out) begin
          pin = b;
          pout = a;
          din = db;
          dout = da;
        end else begin
          pin = a;
          pout = b;
          din = da;
          dout = db;
        end
        len = din - dout;
        if (len != 0) begin
          num = {16'b0, din} << lfc_pkg::FRAC_BITS;
          sc = 32'(num / {16'b0, len});
        end else begin
          sc = lfc_pkg::FP_ONE;
        end
        for (int i = 0; i < 3; i++) pout[i] = pin[i] + fx_mul(pout[i] - pin[i], sc);
        if (a_out) a = pout;
        else b = pout;
      end
    end
    r.a_x = a[0]; r.a_y = a[1]; r.a_z = a[2];
    r.b_x = b[0]; r.b_y = b[1]; r.b_z = b[2];
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst) begin
      seg.valid <= 0;
    end else begin
      if (seg.valid && seg.ready) begin
        expected_clips.push_back(clip_segment({seg.a_x, seg.a_y, seg.a_z,
                                               seg.b_x, seg.b_y, seg.b_z}));
        void'(pending_segs.pop_front());
      end
      if (!(seg.valid && !seg.ready)) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          seg.valid <= 0;
        end else if (pending_segs.size() > 0) begin
          seg.valid <= 1;
          {seg.a_x, seg.a_y, seg.a_z, seg.b_x, seg.b_y, seg.b_z} <= pending_segs[0];
          if (burst_left > 0) begin
            burst_left <= burst_left - 1;
          end else begin
            burst_left <= $urandom_range(40, 0);
            gap_left <= ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(5, 0);
          end
        end else begin
          seg.valid <= 0;
        end
      end
    end
  end

  // receiver stall pattern and checker
  always @(posedge clk) begin
    if (rst) begin
      res.ready <= 0;
    end else begin
      if (res.valid && res.ready) begin
        if (expected_clips.size() == 0) begin
          report("unexpected word", 32'(res.rejected), 32'h0);
        end else begin
          clip_res_t e;
          e = expected_clips.pop_front();
          if (res.rejected !== e.rejected)
            report("rejected", 32'(res.rejected), 32'(e.rejected));
          if (res.out_a_x !== e.a_x) report("out_a_x", res.out_a_x, e.a_x);
          if (res.out_a_y !== e.a_y) report("out_a_y", res.out_a_y, e.a_y);
          if (res.out_a_z !== e.a_z) report("out_a_z", res.out_a_z, e.a_z);
          if (res.out_b_x !== e.b_x) report("out_b_x", res.out_b_x, e.b_x);
          if (res.out_b_y !== e.b_y) report("out_b_y", res.out_b_y, e.b_y);
          if (res.out_b_z !== e.b_z) report("out_b_z", res.out_b_z, e.b_z);
        end
      end
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        res.ready <= 0;
      end else if (cycles % 2000 < 600) begin
        res.ready <= 1;
      end else begin
        res.ready <= ($urandom_range(3, 0) != 0);
      end
    end
  end

  function automatic lfc_pkg::coord_t rand_coord();
    case ($urandom_range(5, 0))
      0: return $urandom;
      1: return 32'h8000_0000 ^ ($urandom_range(1, 0) ? 32'hFFFF_FFFF : 0);
      default: return $signed($urandom_range(20 << 16, 0)) - (10 << 16);
    endcase
  endfunction

  function automatic lfc_pkg::seg_t rand_seg();
    lfc_pkg::seg_t s;
    s.a_x = rand_coord(); s.a_y = rand_coord(); s.a_z = rand_coord();
    s.b_x = rand_coord(); s.b_y = rand_coord(); s.b_z = rand_coord();
    if ($urandom_range(3, 0) != 0) begin
      s.a_z = $urandom_range(12 << 16, 0) - (2 << 16);
      s.b_z = $urandom_range(12 << 16, 0) - (2 << 16);
    end
    return s;
  endfunction

  task automatic write_reg(input logic [lfc_pkg::CFG_IDX_W-1:0] idx,
                           input lfc_pkg::coord_t v);
    @(posedge clk);
    cfg.valid <= 1;
    cfg.index <= idx;
    cfg.wdata <= v;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 0;
    case (idx)
      lfc_pkg::REG_NEAR_Z:  frustum.near_z = v;
      lfc_pkg::REG_SLOPE_X: frustum.slope_x = v;
      default:              frustum.slope_y = v;
    endcase
  endtask

  task automatic drain();
    while (pending_segs.size() > 0 || expected_clips.size() > 0 || seg.valid) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  initial begin
    lfc_pkg::seg_t s;
    lfc_pkg::cfg_t settings[5];
    seg.valid = 0; seg.a_x = 0; seg.a_y = 0; seg.a_z = 0;
    seg.b_x = 0; seg.b_y = 0; seg.b_z = 0;
    res.ready = 0;
    cfg.valid = 0; cfg.index = lfc_pkg::REG_NEAR_Z; cfg.wdata = 0;
    frustum = lfc_pkg::CFG_RESET;
    repeat (9) @(posedge clk);
    rst <= 0;

    // directed: inside, rejected, each plane crossing, extremes
    pending_segs.push_back({32'sh0, 32'sh0, 32'sh2_0000, 32'sh1000, -32'sh1000, 32'sh3_0000});
    pending_segs.push_back({32'sh0, 32'sh0, 32'sh0, 32'sh0, 32'sh0, -32'sh1_0000});
    pending_segs.push_back({32'sh0, 32'sh0, 32'sh0, 32'sh0, 32'sh0, 32'sh4_0000});
    pending_segs.push_back({-32'sh8_0000, 32'sh0, 32'sh2_0000, 32'sh0, 32'sh0, 32'sh2_0000});
    pending_segs.push_back({32'sh8_0000, 32'sh0, 32'sh2_0000, 32'sh0, 32'sh0, 32'sh2_0000});
    pending_segs.push_back({32'sh0, -32'sh8_0000, 32'sh2_0000, 32'sh0, 32'sh0, 32'sh2_0000});
    pending_segs.push_back({32'sh0, 32'sh8_0000, 32'sh2_0000, 32'sh0, 32'sh0, 32'sh2_0000});
    pending_segs.push_back({-32'sh8_0000, 32'sh8_0000, 32'sh0, 32'sh8_0000, -32'sh8_0000,
                            32'sh5_0000});
    pending_segs.push_back({32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                            32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000});
    pending_segs.push_back({32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                            32'h0, 32'h0, 32'h0});
    pending_segs.push_back({32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                            32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF});
    for (int i = 0; i < 4; i++) pending_segs.push_back(rand_seg());
    drain();

    // long receiver hold-off while the sender keeps offering
    for (int i = 0; i < 300; i++) pending_segs.push_back(rand_seg());
    hold_off = 600;
    drain();

    settings[0] = '{near_z: 32'sh0, slope_x: 32'sh0, slope_y: 32'sh0};
    settings[1] = '{near_z: 32'h8000_0000, slope_x: 32'h7FFF_FFFF, slope_y: 32'h8000_0000};
    settings[2] = '{near_z: 32'h7FFF_FFFF, slope_x: 32'h8000_0000, slope_y: 32'h7FFF_FFFF};
    settings[3] = '{near_z: 32'sh8000, slope_x: 32'sh2_0000, slope_y: 32'shC000};
    settings[4] = lfc_pkg::CFG_RESET;
    for (int p = 0; p < 5; p++) begin
      write_reg(lfc_pkg::REG_NEAR_Z, settings[p].near_z);
      write_reg(lfc_pkg::REG_SLOPE_X, settings[p].slope_x);
      write_reg(lfc_pkg::REG_SLOPE_Y, settings[p].slope_y);
      for (int i = 0; i < 280; i++) begin
        s = rand_seg();
        if (p < 3 && $urandom_range(3, 0) == 0) begin
          s.a_x = $urandom; s.a_y = $urandom; s.a_z = $urandom;
        end
        pending_segs.push_back(s);
      end
      drain();
    end
    inputs_done = 1;
  end

  always @(posedge clk) begin
    if (inputs_done) begin
      if (errors == 0) begin
        $display("line_frustum_clipper_core_test: clean");
      end else begin
        $display("line_frustum_clipper_core_test: errors");
      end
      $finish;
    end else if (cycles > CYCLE_LIMIT) begin
      $display("line_frustum_clipper_core_test: errors");
      $finish;
    end
  end

endmodule
